// ===== hdl/mips_subset_core_defines.svh =====
// Assertion macros for the core
`ifndef MIPS_SUBSET_CORE_DEFINES_SVH
`define MIPS_SUBSET_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define MSC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define MSC_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define MSC_ASSERT(label, clk, rst_n, prop)
`define MSC_ASSERT_RST(label, clk, prop)
`endif
`endif

// ===== hdl/msc_pkg.sv =====
// ----------------------------------------------------------------------------
// msc_pkg
// Shared types and constants of the MIPS subset core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package msc_pkg;
  localparam int unsigned MemBytes = 65536;
  localparam int unsigned AddrW    = $clog2(MemBytes);

  localparam logic [2:0] ReqLoadInstr = 3'd0;
  localparam logic [2:0] ReqLoadData  = 3'd1;
  localparam logic [2:0] ReqExec      = 3'd2;
  localparam logic [2:0] ReqReadData  = 3'd3;
  localparam logic [2:0] ReqReadReg   = 3'd4;

  localparam logic [5:0] OpRtype = 6'b000000;
  localparam logic [5:0] OpJ     = 6'b000010;
  localparam logic [5:0] OpBeq   = 6'b000100;
  localparam logic [5:0] OpAddiu = 6'b001001;
  localparam logic [5:0] OpLw    = 6'b100011;
  localparam logic [5:0] OpSw    = 6'b101011;
  localparam logic [31:0] HaltWord = 32'hFFFF_FFFF;

  localparam logic [2:0] FnAddu = 3'd1;
  localparam logic [2:0] FnSubu = 3'd3;
  localparam logic [2:0] FnAnd  = 3'd4;
  localparam logic [2:0] FnOr   = 3'd5;
  localparam logic [2:0] FnNor  = 3'd7;

  // controller -> datapath
  typedef struct packed {
    logic        clr_en;     // clear data memory at clr address
    logic        load_req;   // latch input beat
    logic        imem_wr;    // byte load to instr memory
    logic        dmem_wr_in; // byte load to data memory
    logic        fetch_rd;   // read instr byte at pc + cnt
    logic        fetch_cap;  // shift fetched byte into instruction
    logic        decode;     // capture operands
    logic        data_rd;    // read data byte at eaddr + cnt
    logic        data_cap;   // shift data byte into load word
    logic        sw_wr;      // store byte of rt at eaddr + cnt
    logic        commit;     // register write / pc update
    logic        set_halt;
    logic        rd_data;    // read data byte for read request
    logic        out_cap;    // capture result
    logic [1:0]  cnt;
  } msc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       is_halt;
    logic       is_lw;
    logic       is_sw;
    logic       halted;
    logic [2:0] req;
  } msc_sts_t;
endpackage

// ===== hdl/msc_datapath.sv =====
// ----------------------------------------------------------------------------
// msc_datapath
// Register file, byte memories, pc and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module msc_datapath import msc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  msc_cmd_t         cmd_i,
  input  logic [AddrW-1:0] clr_addr_i,
  input  logic [2:0]       req_type_i,
  input  logic [15:0]      mem_addr_i,
  input  logic [7:0]       byte_value_i,
  input  logic [4:0]       reg_index_i,
  output msc_sts_t         sts_o,
  output logic [31:0]      prog_counter_o,
  output logic             halted_o,
  output logic [31:0]      read_value_o
);
  logic [7:0]  imem [MemBytes];
  logic [7:0]  dmem [MemBytes];
  logic [31:0] rf_q [32];

  logic [2:0]  req_q;
  logic [AddrW-1:0] addr_q;
  logic [7:0]  byte_q;
  logic [4:0]  ridx_q;
  logic [31:0] pc_q, pc_d;
  logic        halt_q;
  logic [31:0] ins_q, a_q, b_q, ldw_q, eaddr_q;
  logic [7:0]  imem_rd_q, dmem_rd_q;
  logic [31:0] rv_q;

  logic [31:0] ins_w, simm, alu, wdata;
  logic [4:0]  waddr;
  logic        wen;
  logic [AddrW-1:0] fadr, dadr, dwadr;
  logic [7:0]  dwdat;
  logic        dwen;

  assign ins_w = {ins_q[23:0], imem_rd_q};
  assign simm  = {{16{ins_q[15]}}, ins_q[15:0]};
  assign fadr  = AddrW'(pc_q + 32'(cmd_i.cnt));
  assign dadr  = cmd_i.rd_data ? addr_q : AddrW'(eaddr_q + 32'(cmd_i.cnt));

  always_comb begin
    dwen  = cmd_i.clr_en | cmd_i.dmem_wr_in | cmd_i.sw_wr;
    dwadr = clr_addr_i;
    dwdat = '0;
    if (cmd_i.dmem_wr_in) begin
      dwadr = addr_q;
      dwdat = byte_q;
    end else if (cmd_i.sw_wr) begin
      dwadr = dadr;
      case (cmd_i.cnt)
        2'd0:    dwdat = b_q[31:24];
        2'd1:    dwdat = b_q[23:16];
        2'd2:    dwdat = b_q[15:8];
        default: dwdat = b_q[7:0];
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.imem_wr) imem[addr_q] <= byte_q;
    if (cmd_i.fetch_rd) imem_rd_q <= imem[fadr];
  end

  always_ff @(posedge clk_i) begin
    if (dwen) dmem[dwadr] <= dwdat;
    if (cmd_i.data_rd || cmd_i.rd_data) dmem_rd_q <= dmem[dadr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q  <= req_type_i;
      addr_q <= AddrW'(mem_addr_i);
      byte_q <= byte_value_i;
      ridx_q <= reg_index_i;
    end
    if (cmd_i.fetch_cap) ins_q <= ins_w;
    if (cmd_i.decode) begin
      a_q     <= rf_q[ins_q[25:21]];
      b_q     <= rf_q[ins_q[20:16]];
      eaddr_q <= rf_q[ins_q[25:21]] + simm;
    end
    if (cmd_i.data_cap) ldw_q <= {ldw_q[23:0], dmem_rd_q};
  end

  always_comb begin
    case (ins_q[2:0])
      FnAddu:  alu = a_q + b_q;
      FnSubu:  alu = a_q - b_q;
      FnAnd:   alu = a_q & b_q;
      FnOr:    alu = a_q | b_q;
      default: alu = ~(a_q | b_q);
    endcase
    wen   = 1'b0;
    waddr = ins_q[20:16];
    wdata = a_q + simm;
    pc_d  = pc_q + 32'd4;
    case (ins_q[31:26])
      OpRtype: begin
        waddr = ins_q[15:11];
        wdata = alu;
        wen   = (ins_q[2:0] inside {FnAddu, FnSubu, FnAnd, FnOr, FnNor});
      end
      OpJ:     pc_d = {pc_d[31:28], ins_q[25:0], 2'b00};
      OpBeq:   if (a_q == b_q) pc_d = pc_d + {simm[29:0], 2'b00};
      OpAddiu: wen = 1'b1;
      OpLw: begin
        wen   = 1'b1;
        wdata = ldw_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= '0;
      halt_q <= 1'b0;
      for (int i = 0; i < 32; i++) rf_q[i] <= '0;
    end else begin
      if (cmd_i.set_halt) halt_q <= 1'b1;
      if (cmd_i.commit) begin
        pc_q <= pc_d;
        if (wen && waddr != 5'd0) rf_q[waddr] <= wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_cap) begin
      prog_counter_o <= pc_q;
      halted_o       <= halt_q;
      case (req_q)
        ReqReadData: rv_q <= {24'd0, dmem_rd_q};
        ReqReadReg:  rv_q <= rf_q[ridx_q];
        default:     rv_q <= '0;
      endcase
    end
  end
  assign read_value_o = rv_q;

  assign sts_o.is_halt = (ins_w == HaltWord);
  assign sts_o.is_lw   = (ins_q[31:26] == OpLw);
  assign sts_o.is_sw   = (ins_q[31:26] == OpSw);
  assign sts_o.halted  = halt_q;
  assign sts_o.req     = req_q;
endmodule

// ===== hdl/msc_ctrl.sv =====
// ----------------------------------------------------------------------------
// msc_ctrl
// Sequencer: memory clear, request handling, fetch / execute, output handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module msc_ctrl import msc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  msc_sts_t         sts_i,
  output msc_cmd_t         cmd_o,
  output logic [AddrW-1:0] clr_addr_o
);
  typedef enum logic [8:0] {
    StClear  = 9'b000000001,
    StIdle   = 9'b000000010,
    StDisp   = 9'b000000100,
    StFetch  = 9'b000001000,
    StDecode = 9'b000010000,
    StLoad   = 9'b000100000,
    StStore  = 9'b001000000,
    StCommit = 9'b010000000,
    StRead   = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic [2:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;
  logic cap;

  assign in_ready_o  = (state_q == StIdle) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign clr_addr_o  = clr_q;

  always_comb begin
    cmd_o       = '0;
    cmd_o.cnt   = cnt_q[1:0];
    state_d     = state_q;
    clr_d       = clr_q;
    cnt_d       = cnt_q;
    cap         = 1'b0;
    case (state_q)
      StClear: begin
        cmd_o.clr_en = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == AddrW'(MemBytes - 1)) state_d = StIdle;
      end
      StIdle: if (in_valid_i && in_ready_o) begin
        cmd_o.load_req = 1'b1;
        state_d = StDisp;
      end
      StDisp: begin
        cnt_d = '0;
        case (sts_i.req)
          ReqLoadInstr: begin cmd_o.imem_wr = 1'b1; cap = 1'b1; end
          ReqLoadData:  begin cmd_o.dmem_wr_in = 1'b1; cap = 1'b1; end
          ReqExec: if (sts_i.halted) cap = 1'b1;
                   else begin
                     cmd_o.fetch_rd = 1'b1;
                     cnt_d = 3'd1;
                     state_d = StFetch;
                   end
          ReqReadData: begin cmd_o.rd_data = 1'b1; state_d = StRead; end
          default: cap = 1'b1;
        endcase
      end
      StFetch: begin
        // byte cnt-1 is on the read port; request byte cnt
        if (cnt_q == 3'd4) begin
          if (sts_i.is_halt) begin
            cmd_o.set_halt = 1'b1;
            state_d = StRead;
          end else begin
            cmd_o.fetch_cap = 1'b1;
            state_d = StDecode;
          end
        end else begin
          cmd_o.fetch_rd  = 1'b1;
          cmd_o.fetch_cap = 1'b1;
          cnt_d = cnt_q + 3'd1;
        end
      end
      StDecode: begin
        cmd_o.decode = 1'b1;
        cnt_d = '0;
        if (sts_i.is_lw) state_d = StLoad;
        else if (sts_i.is_sw) state_d = StStore;
        else state_d = StCommit;
      end
      StLoad: begin
        if (cnt_q != 3'd0) cmd_o.data_cap = 1'b1;
        if (cnt_q == 3'd4) state_d = StCommit;
        else begin
          cmd_o.data_rd = 1'b1;
          cnt_d = cnt_q + 3'd1;
        end
      end
      StStore: begin
        cmd_o.sw_wr = 1'b1;
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd3) state_d = StCommit;
      end
      StCommit: begin
        cmd_o.commit = 1'b1;
        state_d = StRead;
      end
      StRead: begin
        cmd_o.rd_data = 1'b1;
        cap = 1'b1;
      end
      default: state_d = StIdle;
    endcase
    if (cap) begin
      cmd_o.out_cap = 1'b1;
      state_d = StIdle;
    end
    out_valid_d = cap ? 1'b1 : (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end
endmodule

// ===== hdl/mips_subset_core.sv =====
// ----------------------------------------------------------------------------
// mips_subset_core
// MIPS32 subset core with byte-wide instruction and data memories.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_ready_o): one request beat with req_type_i,
// mem_addr_i, byte_value_i and reg_index_i. Output channel (out_valid_o /
// out_ready_i): one result beat per request with prog_counter_o, halted_o and
// read_value_o.
// Byte loads, register reads, unused codes and executes while halted are
// answered from dispatch; data byte reads pass a read state. An execute
// fetches the instruction byte by byte and stops at the halt word; ALU,
// addiu, branch, jump and unknown instructions go on to decode and commit;
// lw and sw make four byte accesses per word on the byte-wide memories
// between the two. One request is in flight at a time: the next beat is
// taken only once the controller is back in idle after the result is captured.
// After reset the data memory is cleared one byte per cycle, MemBytes
// (65536) bytes in all, while in_ready_o stays low. pc, halt flag and the
// register file clear at once.
// A stalled receiver holds the result; no new request is taken until the
// result register is free or drains in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mips_subset_core_defines.svh"
module mips_subset_core import msc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  req_type_i,
  input  logic [15:0] mem_addr_i,
  input  logic [7:0]  byte_value_i,
  input  logic [4:0]  reg_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] prog_counter_o,
  output logic        halted_o,
  output logic [31:0] read_value_o
);
  msc_cmd_t cmd;
  msc_sts_t sts;
  logic [AddrW-1:0] clr_addr;

  msc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd), .clr_addr_o(clr_addr)
  );

  msc_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .clr_addr_i(clr_addr),
    .req_type_i, .mem_addr_i, .byte_value_i, .reg_index_i,
    .sts_o(sts), .prog_counter_o, .halted_o, .read_value_o
  );

  `MSC_ASSERT(a_no_accept_busy, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o)
  `MSC_ASSERT(a_commit_not_halted, clk_i, rst_ni, cmd.commit |-> !sts.halted)
  `MSC_ASSERT(a_halt_sticky, clk_i, rst_ni, sts.halted |=> sts.halted)
  `MSC_ASSERT_RST(a_rst_no_valid, clk_i, !rst_ni |-> !out_valid_o)
endmodule
